// File: hw/rtl/upd_pkg.sv
// upd_pkg: constants, escape phase type and hex helpers for the percent decoder
// no dependencies; imported by uri_percent_decoder
`default_nettype none

package upd_pkg;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_F  = 8'h46;
	localparam logic [3:0] HEX_TEN  = 4'd10;

	localparam int unsigned MAX_RES = 3;
	localparam int unsigned RES_IDX_W = 2;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PCT,
		PH_DIGIT
	} upd_phase_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_lc(input logic [7:0] c);
		return (c >= CH_LC_A) && (c <= CH_LC_F);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || is_lc(c) || ((c >= CH_UC_A) && (c <= CH_UC_F));
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		if (is_dec(c)) begin
			d = c - CH_0;
			return d[3:0];
		end else if (is_lc(c)) begin
			d = c - CH_LC_A;
			return HEX_TEN + d[3:0];
		end else begin
			d = c - CH_UC_A;
			return HEX_TEN + d[3:0];
		end
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/uri_percent_decoder.sv
// uri_percent_decoder: streaming url percent decoder, one input byte per transfer
// depends on upd_pkg
`default_nettype none

// input channel: in_byte/in_last with in_valid, in_stall driven by this block.
// output channel: out_byte/out_last with out_valid, out_stall driven by the sink.
// a transfer happens at a clock edge with valid high and stall low.
// an input transfer lands in the input register; the first decoded byte is then
// loaded from there into the output register once that register is free.
// an input that yields one result is consumed as that result loads, so plain
// text and completed escapes stream at one byte per cycle while the sink does not
// stall. a '%' or a first hex digit yields no result and is consumed even then.
// a broken escape or an end of string inside an escape yields one to three results,
// one per cycle through the single output register while the sink does not stall,
// and in_stall is held high until the last of them is loaded.
// when the sink stalls, the output register holds its transfer and the input
// register holds one more byte; then in_stall rises.
// reset clears the valid flags and drops any pending escape.
module uri_percent_decoder
	import upd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;

	upd_phase_t           phase_q;
	logic [7:0]           held_q;
	logic [RES_IDX_W-1:0] idx_q;

	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 out_last_q;

	logic [7:0]           r_byte [MAX_RES];
	logic [MAX_RES-1:0]   r_last;
	logic [RES_IDX_W-1:0] cnt;
	upd_phase_t           nphase;
	logic [7:0]           nheld;
	logic                 do_fresh;
	logic                 b_hex;
	logic [7:0]           dec_val;

	logic                 out_free;
	logic                 load;
	logic                 consume;
	logic                 accept;
	logic [7:0]           sel_byte;
	logic                 sel_last;

	assign b_hex   = is_hex(byte_s1);
	assign dec_val = {hex_val(held_q), hex_val(byte_s1)};

	// result list for the item in the input register
	always_comb begin
		r_byte   = '{default: '0};
		r_last   = '0;
		cnt      = '0;
		nphase   = phase_q;
		nheld    = held_q;
		do_fresh = 1'b0;
		unique case (phase_q)
			PH_PCT: begin
				if (b_hex) begin
					if (last_s1) begin
						r_byte[0] = CH_PCT;
						r_byte[1] = byte_s1;
						r_last[1] = 1'b1;
						cnt       = 2'd2;
						nphase    = PH_IDLE;
					end else begin
						nheld  = byte_s1;
						nphase = PH_DIGIT;
					end
				end else begin
					r_byte[0] = CH_PCT;
					cnt       = 2'd1;
					do_fresh  = 1'b1;
				end
			end
			PH_DIGIT: begin
				if (b_hex) begin
					r_byte[0] = dec_val;
					r_last[0] = last_s1;
					cnt       = 2'd1;
					nphase    = PH_IDLE;
				end else begin
					r_byte[0] = CH_PCT;
					r_byte[1] = held_q;
					cnt       = 2'd2;
					do_fresh  = 1'b1;
				end
			end
			default: begin
				do_fresh = 1'b1;
			end
		endcase
		if (do_fresh) begin
			if (byte_s1 == CH_PCT && !last_s1) begin
				nphase = PH_PCT;
			end else begin
				r_byte[cnt] = byte_s1;
				r_last[cnt] = last_s1;
				cnt         = cnt + 2'd1;
				nphase      = PH_IDLE;
			end
		end
	end

	always_comb begin
		unique case (idx_q)
			2'd0:    begin sel_byte = r_byte[0]; sel_last = r_last[0]; end
			2'd1:    begin sel_byte = r_byte[1]; sel_last = r_last[1]; end
			default: begin sel_byte = r_byte[2]; sel_last = r_last[2]; end
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;
	assign load     = valid_s1 && out_free && (cnt != '0);
	assign consume  = valid_s1 && ((cnt == '0) || (out_free && idx_q == cnt - 2'd1));
	assign in_stall = valid_s1 && !consume;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			phase_q     <= PH_IDLE;
			held_q      <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
			if (consume) begin
				idx_q   <= '0;
				phase_q <= nphase;
				held_q  <= nheld;
			end else if (load) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
		if (load) begin
			out_byte_q <= sel_byte;
			out_last_q <= sel_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

// File: hw/rtl/upd_checker.sv
// upd_checker: port-level assertions for uri_percent_decoder, bound into every uri_percent_decoder instance
// depends on uri_percent_decoder ports only
`default_nettype none

module upd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] in_byte,
	input wire logic       in_last,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       out_last
);

	// stalled output transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled output changed");

	// a stalled input stays stalled while the sink stalls
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall ##1 out_stall |-> in_stall)
		else $error("input stall released with sink stalled");

	// input stall with an empty output register means a result is on its way
	a_stall_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_valid |=> out_valid)
		else $error("input stalled without output progress");

	// no input stall and no valid output right after reset
	a_reset_clear: assert property (@(posedge clk)
		$rose(arst_n) |-> !in_stall && !out_valid)
		else $error("pipeline not empty after reset");

endmodule

bind uri_percent_decoder upd_checker u_upd_checker (.*);

`default_nettype wire
